### rtl/core/crs_pkg.sv
// Shared types and codes for the clipping rectangle stack.
package crs_pkg;

    // Rectangle edges, left edge in the lowest bits
    typedef struct packed {
        logic signed [15:0] bottom;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] left;
    } rect_t;

    // Shift controls broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

    // One result transaction
    typedef struct packed {
        logic [1:0] status;
        rect_t      rect;
    } result_t;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_VP_WIDTH  = 1'b0;
    localparam logic REG_VP_HEIGHT = 1'b1;

    // Viewport reset values
    localparam logic [14:0] VP_WIDTH_RST  = 15'd640;
    localparam logic [14:0] VP_HEIGHT_RST = 15'd480;

endpackage

### rtl/core/crs_cell.sv
// One stack cell: holds a rectangle and shifts with its neighbors.
module crs_cell (
    input  logic                clk,
    input  crs_pkg::shift_ctl_t ctl,
    input  crs_pkg::rect_t      up_in,
    input  crs_pkg::rect_t      down_in,
    output crs_pkg::rect_t      q
);
    import crs_pkg::*;

    rect_t entry_reg;
    rect_t entry_next;

    // Take the entry above on push, the entry below on pop, else hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = up_in;
        end
        else if (ctl.pop)
        begin
            entry_next = down_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### rtl/core/crs_skid.sv
// Output register with a skid stage for the result stream.
module crs_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  crs_pkg::result_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output crs_pkg::result_t out_item
);
    import crs_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_item_reg;
    result_t out_item_next;
    result_t skid_item_reg;
    result_t skid_item_next;
    logic    in_fire;
    logic    out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Refill the output from the skid stage first, then from the input
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_item_next   = skid_item_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_item_next  = in_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_item_next  = in_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/core/clip_rect_stack_unit.sv
// Top level of the clipping rectangle stack.
//
//  port group   dir  fields (low bit up)
//  s_*          in   tdata: rect_left, rect_top, rect_right, rect_bottom; tuser: opcode
//  m_*          out  tdata: scissor_left/top/right/bottom; tuser: status
//  p*           in   APB: 0x0 viewport_width, 0x4 viewport_height
//
// One push or pop transaction is taken per cycle while s_tready is high; its result
// is registered in the output buffer before it appears on m_*. The stack is a chain of
// cells with the top in cell 0, so a push or pop is one shift of the chain.
// A two-entry output buffer keeps s_tready high for one stalled result;
// s_tready drops only while both entries hold results.
// Reset clears the entry count, the output buffer and the viewport to
// 640 x 480; cell contents are not reset and are written before use.
module clip_rect_stack_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rect_left, rect_top, rect_right, rect_bottom
    input  logic [0:0]  s_tuser,   // opcode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // scissor_left, scissor_top, scissor_right, scissor_bottom
    output logic [1:0]  m_tuser,   // status
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import crs_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [14:0]      vp_width_reg;
    logic [14:0]      vp_height_reg;

    rect_t      cell_q    [STACK_DEPTH];
    rect_t      down_rect [STACK_DEPTH];
    rect_t      new_rect;
    rect_t      top_rect;
    rect_t      clamped;
    rect_t      push_rect;
    rect_t      viewport;
    shift_ctl_t ctl;
    result_t    result;
    logic       accept;
    logic       is_push;
    logic       full;
    logic       empty;
    logic       cfg_write;
    logic       result_ready;

    assign new_rect = s_tdata;
    assign is_push  = (s_tuser[0] == OP_PUSH);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign top_rect = cell_q[0];

    assign viewport.left   = 16'sd0;
    assign viewport.top    = 16'sd0;
    assign viewport.right  = {1'b0, vp_width_reg};
    assign viewport.bottom = {1'b0, vp_height_reg};

    // Clamp the current top into the new rectangle
    always_comb
    begin
        clamped.left   = (top_rect.left > new_rect.left) ? top_rect.left : new_rect.left;
        clamped.left   = (clamped.left < new_rect.right) ? clamped.left : new_rect.right;
        clamped.top    = (top_rect.top > new_rect.top) ? top_rect.top : new_rect.top;
        clamped.top    = (clamped.top < new_rect.bottom) ? clamped.top : new_rect.bottom;
        clamped.right  = (top_rect.right < new_rect.right) ? top_rect.right : new_rect.right;
        clamped.right  = (clamped.right > new_rect.left) ? clamped.right : new_rect.left;
        clamped.bottom = (top_rect.bottom < new_rect.bottom) ? top_rect.bottom
                                                             : new_rect.bottom;
        clamped.bottom = (clamped.bottom > new_rect.top) ? clamped.bottom : new_rect.top;
    end

    assign push_rect = empty ? new_rect : clamped;

    // Shift the chain only on a push that fits or a pop that has an entry
    assign ctl.push = accept && is_push && !full;
    assign ctl.pop  = accept && !is_push && !empty;

    // Build the chain of cells, top of stack in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            if (gi + 1 < STACK_DEPTH)
            begin : g_mid
                assign down_rect[gi] = cell_q[gi+1];
            end
            else
            begin : g_last
                assign down_rect[gi] = cell_q[gi];
            end

            if (gi == 0)
            begin : g_head
                crs_cell u_cell (
                    .clk     (clk),
                    .ctl     (ctl),
                    .up_in   (push_rect),
                    .down_in (down_rect[gi]),
                    .q       (cell_q[gi])
                );
            end
            else
            begin : g_body
                crs_cell u_cell (
                    .clk     (clk),
                    .ctl     (ctl),
                    .up_in   (cell_q[gi-1]),
                    .down_in (down_rect[gi]),
                    .q       (cell_q[gi])
                );
            end
        end
    endgenerate

    // Select the scissor in force after the operation
    always_comb
    begin
        result.status = ST_OK;
        result.rect   = viewport;
        count_next    = count_reg;
        if (is_push)
        begin
            if (full)
            begin
                result.status = ST_FULL;
                result.rect   = top_rect;
            end
            else
            begin
                result.rect = push_rect;
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                result.status = ST_EMPTY;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg != CNT_W'(1))
                begin
                    result.rect = down_rect[0];
                end
            end
        end
    end

    // Advance the entry count on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    crs_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (result_ready),
        .in_item   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  ({m_tuser, m_tdata})
    );

    assign s_tready = result_ready;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_width_reg  <= VP_WIDTH_RST;
            vp_height_reg <= VP_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_VP_WIDTH:  vp_width_reg  <= pwdata[14:0];
                REG_VP_HEIGHT: vp_height_reg <= pwdata[14:0];
                default:       vp_width_reg  <= vp_width_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_VP_WIDTH:  prdata = {17'd0, vp_width_reg};
            REG_VP_HEIGHT: prdata = {17'd0, vp_height_reg};
            default:       prdata = '0;
        endcase
    end

    // The entry count never passes the stack depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    // A push onto a full stack leaves it full
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_push && full |=> count_reg == CNT_W'(STACK_DEPTH))
        else $error("dropped push changed the entry count");

    // A pop of an empty stack leaves it empty
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_push && empty |=> count_reg == '0)
        else $error("pop of empty stack changed the entry count");

    // A push onto an empty stack leaves one entry
    a_first_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_push && empty |=> count_reg == CNT_W'(1))
        else $error("first push did not store one entry");

endmodule
